>>> src/pnt_pkg.sv
// ----------------------------------------------------------------------------
// pnt_pkg
// Shared types and constants of the gradient-noise turbulence unit.
// ----------------------------------------------------------------------------
package pnt_pkg;

    localparam int TABLE_SIZE      = 256;
    localparam int IDX_W           = $clog2(TABLE_SIZE);
    localparam int FRAC_BITS       = 16;
    localparam int MAX_OCTAVES_DEF = 8;
    localparam int OCT_W           = 5;
    localparam int OUT_W           = 17;
    localparam int OP_A_W          = 22;
    localparam int OP_B_W          = 19;
    localparam int PROD_W          = OP_A_W + OP_B_W;
    localparam int ACC_W           = 44;
    localparam int SUM_W           = 23;
    localparam int JOBQ_DEPTH      = 4;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    localparam logic [2:0] CMD_GRAD   = 3'd0;
    localparam logic [2:0] CMD_PERM_X = 3'd1;
    localparam logic [2:0] CMD_PERM_Y = 3'd2;
    localparam logic [2:0] CMD_PERM_Z = 3'd3;
    localparam logic [2:0] CMD_EVAL   = 3'd4;

    typedef enum logic [2:0] {
        JOB_GRAD,
        JOB_PERM_X,
        JOB_PERM_Y,
        JOB_PERM_Z,
        JOB_EVAL
    } t_job_kind;

    typedef struct packed {
        t_job_kind          kind;
        logic [IDX_W-1:0]   idx;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] gz;
        logic [7:0]         pv;
        logic [31:0]        px;
        logic [31:0]        py;
        logic [31:0]        pz;
        logic [OCT_W-1:0]   oct;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FADE_SQ,
        ST_FADE_MUL,
        ST_FADE_CAP,
        ST_PERM,
        ST_GRAD,
        ST_DOT_X,
        ST_DOT_Y,
        ST_DOT_Z,
        ST_DOT_CAP,
        ST_LERP_A,
        ST_LERP_B,
        ST_LERP_CAP,
        ST_ACCUM,
        ST_DONE
    } t_state;

endpackage

>>> src/perlin_noise_turbulence_unit.sv
// A table write takes effect in the cycle after it leaves the job queue.
// An evaluate with zero octaves goes straight to its result. Each octave computes
// the fade weights, then the lattice corner dot products with the blends between
// them, all on one shared multiply-add; one item is in the core at a time.
// Reset (synchronous, active low) empties both queues and idles the core;
// the tables keep their contents and must be loaded before use.
// ----------------------------------------------------------------------------
// perlin_noise_turbulence_unit
// 3D gradient-noise turbulence with loadable gradient and permutation tables.
// ----------------------------------------------------------------------------
module perlin_noise_turbulence_unit #(
    parameter int MAX_OCTAVES = pnt_pkg::MAX_OCTAVES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [2:0]                  i_cmd,
    input  logic [7:0]                  i_table_index,
    input  logic signed [15:0]          i_grad_x,
    input  logic signed [15:0]          i_grad_y,
    input  logic signed [15:0]          i_grad_z,
    input  logic [7:0]                  i_perm_value,
    input  logic signed [31:0]          i_point_x,
    input  logic signed [31:0]          i_point_y,
    input  logic signed [31:0]          i_point_z,
    input  logic [3:0]                  i_octaves,
    output logic                        empty,
    input  logic                        pop,
    output logic [pnt_pkg::OUT_W-1:0]   o_noise_value
);

    pnt_pkg::t_job             w_job;
    logic                      w_job_valid, w_job_pop;
    logic                      w_res_valid, w_res_full;
    logic [pnt_pkg::OUT_W-1:0] w_res;

    pnt_front #(
        .MAX_OCTAVES (MAX_OCTAVES),
        .DEPTH       (pnt_pkg::JOBQ_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_cmd         (i_cmd),
        .i_table_index (i_table_index),
        .i_grad_x      (i_grad_x),
        .i_grad_y      (i_grad_y),
        .i_grad_z      (i_grad_z),
        .i_perm_value  (i_perm_value),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_octaves     (i_octaves),
        .o_job_valid   (w_job_valid),
        .o_job         (w_job),
        .i_job_pop     (w_job_pop)
    );

    pnt_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    pnt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_noise_value)
    );

endmodule

>>> src/pnt_front.sv
// ----------------------------------------------------------------------------
// pnt_front
// Accepts input items, sorts out the command and queues jobs for the core.
// ----------------------------------------------------------------------------
module pnt_front #(
    parameter int MAX_OCTAVES = pnt_pkg::MAX_OCTAVES_DEF,
    parameter int DEPTH       = pnt_pkg::JOBQ_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [2:0]             i_cmd,
    input  logic [7:0]             i_table_index,
    input  logic signed [15:0]     i_grad_x,
    input  logic signed [15:0]     i_grad_y,
    input  logic signed [15:0]     i_grad_z,
    input  logic [7:0]             i_perm_value,
    input  logic signed [31:0]     i_point_x,
    input  logic signed [31:0]     i_point_y,
    input  logic signed [31:0]     i_point_z,
    input  logic [3:0]             i_octaves,
    output logic                   o_job_valid,
    output pnt_pkg::t_job          o_job,
    input  logic                   i_job_pop
);

    localparam int PTR_W = $clog2(DEPTH);

    pnt_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_cnt;
    logic [PTR_W:0]   n_cnt;

    pnt_pkg::t_job    w_job;
    logic             w_known;
    logic             w_enq;
    logic             w_deq;

    always_comb begin
        w_job      = '0;
        w_known    = 1'b1;
        w_job.idx  = i_table_index[pnt_pkg::IDX_W-1:0];
        w_job.gx   = i_grad_x;
        w_job.gy   = i_grad_y;
        w_job.gz   = i_grad_z;
        w_job.pv   = i_perm_value;
        w_job.px   = i_point_x;
        w_job.py   = i_point_y;
        w_job.pz   = i_point_z;
        if ({1'b0, i_octaves} > pnt_pkg::OCT_W'(MAX_OCTAVES)) begin
            w_job.oct = pnt_pkg::OCT_W'(MAX_OCTAVES);
        end else begin
            w_job.oct = {1'b0, i_octaves};
        end
        unique case (i_cmd)
            pnt_pkg::CMD_GRAD:   w_job.kind = pnt_pkg::JOB_GRAD;
            pnt_pkg::CMD_PERM_X: w_job.kind = pnt_pkg::JOB_PERM_X;
            pnt_pkg::CMD_PERM_Y: w_job.kind = pnt_pkg::JOB_PERM_Y;
            pnt_pkg::CMD_PERM_Z: w_job.kind = pnt_pkg::JOB_PERM_Z;
            pnt_pkg::CMD_EVAL:   w_job.kind = pnt_pkg::JOB_EVAL;
            default: begin
                // Unknown commands are taken and dropped.
                w_job.kind = pnt_pkg::JOB_EVAL;
                w_known    = 1'b0;
            end
        endcase
    end

    assign full        = (r_cnt == (PTR_W+1)'(DEPTH));
    assign w_enq       = push && !full && w_known;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_mem[r_rd];
    assign w_deq       = i_job_pop && o_job_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_enq && !w_deq) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_enq && w_deq) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_enq) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_deq) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_mem[r_wr] <= w_job;
        end
    end

endmodule

>>> src/pnt_core.sv
// ----------------------------------------------------------------------------
// pnt_core
// Holds the tables and evaluates noise octaves on one shared multiply-add.
// ----------------------------------------------------------------------------
module pnt_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  pnt_pkg::t_job               i_job,
    output logic                        o_job_pop,
    output logic                        o_res_valid,
    output logic [pnt_pkg::OUT_W-1:0]   o_res,
    input  logic                        i_res_full
);

    localparam int IW = pnt_pkg::IDX_W;
    localparam int F  = pnt_pkg::FRAC_BITS;
    localparam int AW = pnt_pkg::OP_A_W;
    localparam int BW = pnt_pkg::OP_B_W;
    localparam int CW = pnt_pkg::ACC_W;
    localparam int OW = pnt_pkg::OCT_W;
    localparam int SW = pnt_pkg::SUM_W;

    localparam logic signed [BW-1:0] ONE       = BW'(1 << F);
    localparam logic signed [BW-1:0] THREE_ONE = BW'(3 << F);

    logic [47:0]   r_grad_mem [pnt_pkg::TABLE_SIZE];
    logic [7:0]    r_permx_mem [pnt_pkg::TABLE_SIZE];
    logic [7:0]    r_permy_mem [pnt_pkg::TABLE_SIZE];
    logic [7:0]    r_permz_mem [pnt_pkg::TABLE_SIZE];

    pnt_pkg::t_state r_state, n_state;

    logic [1:0]             r_axis;
    logic [2:0]             r_corner;
    logic [1:0]             r_level;
    logic [OW-1:0]          r_oct_n, r_oct_cnt;
    logic [31:0]            r_px, r_py, r_pz;
    logic [F:0]             r_su, r_sv, r_sw;
    logic signed [CW-1:0]   r_acc, n_acc;
    logic signed [AW-1:0]   r_d0, r_d1, r_xa, r_ya, r_lr;
    logic [SW-1:0]          r_sum;
    logic [7:0]             r_pxv, r_pyv, r_pzv;
    logic [47:0]            r_g;

    logic                   w_di, w_dj, w_dk;
    logic [F-1:0]           w_u, w_v, w_w, w_frac;
    logic signed [AW-1:0]   w_a, w_dval, w_lval, w_la, w_lb;
    logic signed [BW-1:0]   w_b;
    logic [F:0]             w_s;
    logic                   w_clr;
    logic                   w_mac;
    logic signed [pnt_pkg::PROD_W-1:0] w_prod;
    logic [7:0]             w_hash;
    logic [AW-1:0]          w_abs;
    logic                   w_start, w_write;

    assign w_di   = r_corner[0];
    assign w_dj   = r_corner[1];
    assign w_dk   = r_corner[2];
    assign w_u    = r_px[F-1:0];
    assign w_v    = r_py[F-1:0];
    assign w_w    = r_pz[F-1:0];
    assign w_hash = r_pxv ^ r_pyv ^ r_pzv;

    // Floor shifts of the accumulator are plain slices of its two's complement.
    assign w_dval = signed'(r_acc[14 +: AW]);
    assign w_lval = signed'(r_acc[F +: AW]);
    assign w_abs  = w_lval[AW-1] ? AW'(-w_lval) : AW'(w_lval);

    assign w_start = (r_state == pnt_pkg::ST_IDLE) && i_job_valid;
    assign w_write = w_start && (i_job.kind != pnt_pkg::JOB_EVAL);

    always_comb begin
        unique case (r_axis)
            2'd0:    w_frac = w_u;
            2'd1:    w_frac = w_v;
            default: w_frac = w_w;
        endcase
    end

    always_comb begin
        unique case (r_level)
            2'd0: begin
                w_s  = r_su;
                w_la = r_d0;
                w_lb = r_d1;
            end
            2'd1: begin
                w_s  = r_sv;
                w_la = r_xa;
                w_lb = r_lr;
            end
            default: begin
                w_s  = r_sw;
                w_la = r_ya;
                w_lb = r_lr;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pnt_pkg::ST_IDLE: begin
                if (i_job_valid && (i_job.kind == pnt_pkg::JOB_EVAL)) begin
                    n_state = (i_job.oct == '0) ? pnt_pkg::ST_DONE : pnt_pkg::ST_FADE_SQ;
                end
            end
            pnt_pkg::ST_FADE_SQ:  n_state = pnt_pkg::ST_FADE_MUL;
            pnt_pkg::ST_FADE_MUL: n_state = pnt_pkg::ST_FADE_CAP;
            pnt_pkg::ST_FADE_CAP: begin
                n_state = (r_axis == 2'd2) ? pnt_pkg::ST_PERM : pnt_pkg::ST_FADE_SQ;
            end
            pnt_pkg::ST_PERM:     n_state = pnt_pkg::ST_GRAD;
            pnt_pkg::ST_GRAD:     n_state = pnt_pkg::ST_DOT_X;
            pnt_pkg::ST_DOT_X:    n_state = pnt_pkg::ST_DOT_Y;
            pnt_pkg::ST_DOT_Y:    n_state = pnt_pkg::ST_DOT_Z;
            pnt_pkg::ST_DOT_Z:    n_state = pnt_pkg::ST_DOT_CAP;
            pnt_pkg::ST_DOT_CAP: begin
                n_state = w_di ? pnt_pkg::ST_LERP_A : pnt_pkg::ST_PERM;
            end
            pnt_pkg::ST_LERP_A:   n_state = pnt_pkg::ST_LERP_B;
            pnt_pkg::ST_LERP_B:   n_state = pnt_pkg::ST_LERP_CAP;
            pnt_pkg::ST_LERP_CAP: begin
                unique case (r_level)
                    2'd0:    n_state = w_dj ? pnt_pkg::ST_LERP_A : pnt_pkg::ST_PERM;
                    2'd1:    n_state = w_dk ? pnt_pkg::ST_LERP_A : pnt_pkg::ST_PERM;
                    default: n_state = pnt_pkg::ST_ACCUM;
                endcase
            end
            pnt_pkg::ST_ACCUM: begin
                n_state = ((r_oct_n + 1'b1) == r_oct_cnt) ? pnt_pkg::ST_DONE
                                                          : pnt_pkg::ST_FADE_SQ;
            end
            pnt_pkg::ST_DONE: begin
                if (!i_res_full) begin
                    n_state = pnt_pkg::ST_IDLE;
                end
            end
            default: n_state = pnt_pkg::ST_IDLE;
        endcase
    end

    // Outputs and multiply-add operand selection.
    always_comb begin
        o_job_pop   = w_start;
        o_res_valid = (r_state == pnt_pkg::ST_DONE);
        o_res       = (r_sum > SW'(pnt_pkg::OUT_MAX)) ? pnt_pkg::OUT_MAX
                                                      : r_sum[pnt_pkg::OUT_W-1:0];
        w_a   = '0;
        w_b   = '0;
        w_clr = 1'b1;
        w_mac = 1'b1;
        unique case (r_state)
            pnt_pkg::ST_FADE_SQ: begin
                w_a = AW'(w_frac);
                w_b = BW'(w_frac);
            end
            pnt_pkg::ST_FADE_MUL: begin
                w_a = AW'(r_acc[F +: F]);
                w_b = THREE_ONE - BW'({w_frac, 1'b0});
            end
            pnt_pkg::ST_DOT_X: begin
                w_a = AW'(signed'(r_g[47:32]));
                w_b = BW'(w_u) - (w_di ? ONE : '0);
            end
            pnt_pkg::ST_DOT_Y: begin
                w_a   = AW'(signed'(r_g[31:16]));
                w_b   = BW'(w_v) - (w_dj ? ONE : '0);
                w_clr = 1'b0;
            end
            pnt_pkg::ST_DOT_Z: begin
                w_a   = AW'(signed'(r_g[15:0]));
                w_b   = BW'(w_w) - (w_dk ? ONE : '0);
                w_clr = 1'b0;
            end
            pnt_pkg::ST_LERP_A: begin
                w_a = w_la;
                w_b = ONE - BW'(w_s);
            end
            pnt_pkg::ST_LERP_B: begin
                w_a   = w_lb;
                w_b   = BW'(w_s);
                w_clr = 1'b0;
            end
            default: w_mac = 1'b0;
        endcase
        w_prod = w_a * w_b;
        n_acc  = (w_clr ? '0 : r_acc) + CW'(w_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pnt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mac) begin
            r_acc <= n_acc;
        end
        unique case (r_state)
            pnt_pkg::ST_IDLE: begin
                r_px      <= i_job.px;
                r_py      <= i_job.py;
                r_pz      <= i_job.pz;
                r_oct_cnt <= i_job.oct;
                r_oct_n   <= '0;
                r_sum     <= '0;
                r_axis    <= '0;
                r_corner  <= '0;
            end
            pnt_pkg::ST_FADE_CAP: begin
                unique case (r_axis)
                    2'd0:    r_su <= r_acc[F +: F+1];
                    2'd1:    r_sv <= r_acc[F +: F+1];
                    default: r_sw <= r_acc[F +: F+1];
                endcase
                r_axis <= r_axis + 1'b1;
            end
            pnt_pkg::ST_DOT_CAP: begin
                if (w_di) begin
                    r_d1    <= w_dval;
                    r_level <= '0;
                end else begin
                    r_d0     <= w_dval;
                    r_corner <= r_corner + 1'b1;
                end
            end
            pnt_pkg::ST_LERP_CAP: begin
                r_lr    <= w_lval;
                r_level <= r_level + 1'b1;
                if (r_level == 2'd0 && !w_dj) begin
                    r_xa     <= w_lval;
                    r_corner <= r_corner + 1'b1;
                end
                if (r_level == 2'd1 && !w_dk) begin
                    r_ya     <= w_lval;
                    r_corner <= r_corner + 1'b1;
                end
            end
            pnt_pkg::ST_ACCUM: begin
                r_sum    <= r_sum + SW'(w_abs >> r_oct_n);
                r_oct_n  <= r_oct_n + 1'b1;
                r_px     <= {r_px[30:0], 1'b0};
                r_py     <= {r_py[30:0], 1'b0};
                r_pz     <= {r_pz[30:0], 1'b0};
                r_axis   <= '0;
                r_corner <= '0;
            end
            default: begin
            end
        endcase
    end

    // Lattice lookups: permutation reads, then the gradient read in the following cycle.
    always_ff @(posedge i_clk) begin
        if (w_write && i_job.kind == pnt_pkg::JOB_PERM_X) begin
            r_permx_mem[i_job.idx] <= i_job.pv;
        end
        if (r_state == pnt_pkg::ST_PERM) begin
            r_pxv <= r_permx_mem[r_px[F +: IW] + IW'(w_di)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write && i_job.kind == pnt_pkg::JOB_PERM_Y) begin
            r_permy_mem[i_job.idx] <= i_job.pv;
        end
        if (r_state == pnt_pkg::ST_PERM) begin
            r_pyv <= r_permy_mem[r_py[F +: IW] + IW'(w_dj)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write && i_job.kind == pnt_pkg::JOB_PERM_Z) begin
            r_permz_mem[i_job.idx] <= i_job.pv;
        end
        if (r_state == pnt_pkg::ST_PERM) begin
            r_pzv <= r_permz_mem[r_pz[F +: IW] + IW'(w_dk)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write && i_job.kind == pnt_pkg::JOB_GRAD) begin
            r_grad_mem[i_job.idx] <= {i_job.gx, i_job.gy, i_job.gz};
        end
        if (r_state == pnt_pkg::ST_GRAD) begin
            r_g <= r_grad_mem[w_hash[IW-1:0]];
        end
    end

endmodule

>>> src/pnt_outq.sv
// ----------------------------------------------------------------------------
// pnt_outq
// Two-entry result queue between the core and the result ports.
// ----------------------------------------------------------------------------
module pnt_outq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [pnt_pkg::OUT_W-1:0]  i_data,
    output logic                       o_full,
    output logic                       empty,
    input  logic                       pop,
    output logic [pnt_pkg::OUT_W-1:0]  o_data
);

    logic [pnt_pkg::OUT_W-1:0] r_q0, r_q1;
    logic [1:0]                r_cnt;
    logic                      w_wr, w_rd;

    assign o_full = (r_cnt == 2'd2);
    assign empty  = (r_cnt == 2'd0);
    assign o_data = r_q0;
    assign w_wr   = i_valid && !o_full;
    assign w_rd   = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    // Entry 0 is always the oldest result.
    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_q0 <= (w_wr && r_cnt == 2'd1) ? i_data : r_q1;
        end else if (w_wr && r_cnt == 2'd0) begin
            r_q0 <= i_data;
        end
        if (w_wr && ((r_cnt == 2'd1 && !w_rd) || (r_cnt == 2'd2))) begin
            r_q1 <= i_data;
        end
    end

endmodule

>>> src/pnt_checker.sv
// ----------------------------------------------------------------------------
// pnt_checker
// Port-level checks of the turbulence unit, bound to the top level.
// ----------------------------------------------------------------------------
module pnt_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       push,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic [pnt_pkg::OUT_W-1:0]  o_noise_value
);

    // After reset no stale result may show and the input side must be open.
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_rst_open: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input full after reset");

    // A waiting result holds until its transfer.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_noise_value)))
        else $error("waiting result changed before transfer");

endmodule

bind perlin_noise_turbulence_unit pnt_checker u_pnt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_noise_value (o_noise_value)
);

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Loads the gradient and permutation tables, then runs a directed set of
// evaluate and write transfers followed by a random mix. A local fixed-point
// noise predictor supplies the expected turbulence unless a row gives its own.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [2:0] CMD_RSVD_A = 3'd5;
    localparam logic [2:0] CMD_RSVD_B = 3'd6;
    localparam logic [2:0] CMD_LAST   = 3'd7;
    localparam int         IDLE_LIMIT = 20000;
    localparam int         DRAIN_WAIT = 700;
    localparam int         N_RANDOM   = 700;
    localparam longint     ONE_Q      = 64'sd65536;

    typedef struct {
        logic [2:0]                cmd;
        logic [7:0]                idx;
        logic signed [15:0]        gx, gy, gz;
        logic [7:0]                pv;
        logic [31:0]               px, py, pz;
        logic [3:0]                oct;
        bit                        typed;
        logic [pnt_pkg::OUT_W-1:0] want;
    } t_stim;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      push = 1'b0;
    logic                      pop = 1'b0;
    logic                      full, empty;
    logic [2:0]                i_cmd = '0;
    logic [7:0]                i_table_index = '0;
    logic signed [15:0]        i_grad_x = '0, i_grad_y = '0, i_grad_z = '0;
    logic [7:0]                i_perm_value = '0;
    logic signed [31:0]        i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic [3:0]                i_octaves = '0;
    logic [pnt_pkg::OUT_W-1:0] o_noise_value;

    // Local copy of the tables, updated in transfer order.
    logic signed [15:0] grad_mem [0:pnt_pkg::TABLE_SIZE-1][0:2];
    logic [7:0]         perm_mem [0:2][0:pnt_pkg::TABLE_SIZE-1];

    logic [pnt_pkg::OUT_W-1:0] noise_expected_q[$];
    int errors = 0;
    int idle_cycles = 0;
    int n_evals = 0;
    int n_writes = 0;
    int n_results = 0;
    int stall_phase = 0;

    perlin_noise_turbulence_unit uut (.*);

    always #5 i_clk = ~i_clk;

    function automatic longint fade_weight(longint u);
        longint uu;
        uu = (u * u) >>> 16;
        return (uu * (3 * ONE_Q - 2 * u)) >>> 16;
    endfunction

    function automatic longint blend(longint a, longint b, longint s);
        return (a * (ONE_Q - s) + b * s) >>> 16;
    endfunction

    function automatic longint octave_noise(logic [31:0] px, logic [31:0] py,
                                            logic [31:0] pz);
        longint cx, cy, cz, u, v, w, d[8], x00, x10, x01, x11, y0, y1, r;
        longint ox, oy, oz;
        logic [7:0] h;
        cx = longint'($signed(px)) >>> 16;
        cy = longint'($signed(py)) >>> 16;
        cz = longint'($signed(pz)) >>> 16;
        u = px[15:0];
        v = py[15:0];
        w = pz[15:0];
        for (int c = 0; c < 8; c++) begin
            // Corner bits: x in bit 2, y in bit 1, z in bit 0.
            h = perm_mem[0][8'(cx + c[2])] ^ perm_mem[1][8'(cy + c[1])]
                ^ perm_mem[2][8'(cz + c[0])];
            ox = u - c[2] * ONE_Q;
            oy = v - c[1] * ONE_Q;
            oz = w - c[0] * ONE_Q;
            d[c] = (longint'(grad_mem[h][0]) * ox + longint'(grad_mem[h][1]) * oy
                    + longint'(grad_mem[h][2]) * oz) >>> 14;
        end
        x00 = blend(d[0], d[4], fade_weight(u));
        x10 = blend(d[2], d[6], fade_weight(u));
        x01 = blend(d[1], d[5], fade_weight(u));
        x11 = blend(d[3], d[7], fade_weight(u));
        y0  = blend(x00, x10, fade_weight(v));
        y1  = blend(x01, x11, fade_weight(v));
        r   = blend(y0, y1, fade_weight(w));
        return (r < 0) ? -r : r;
    endfunction

    function automatic logic [pnt_pkg::OUT_W-1:0] turbulence(t_stim s);
        longint sum;
        int n_oct;
        logic [31:0] px, py, pz;
        sum = 0;
        px = s.px;
        py = s.py;
        pz = s.pz;
        n_oct = (s.oct > pnt_pkg::MAX_OCTAVES_DEF) ? pnt_pkg::MAX_OCTAVES_DEF : s.oct;
        for (int n = 0; n < n_oct; n++) begin
            sum += octave_noise(px, py, pz) >> n;
            px = px << 1;
            py = py << 1;
            pz = pz << 1;
        end
        return (sum > longint'(pnt_pkg::OUT_MAX)) ? pnt_pkg::OUT_MAX
                                                  : sum[pnt_pkg::OUT_W-1:0];
    endfunction

    // Drives one item and returns once the transfer has happened.
    task automatic send(t_stim s);
        push          <= 1'b1;
        i_cmd         <= s.cmd;
        i_table_index <= s.idx;
        i_grad_x      <= s.gx;
        i_grad_y      <= s.gy;
        i_grad_z      <= s.gz;
        i_perm_value  <= s.pv;
        i_point_x     <= s.px;
        i_point_y     <= s.py;
        i_point_z     <= s.pz;
        i_octaves     <= s.oct;
        do @(posedge i_clk); while (full);
        case (s.cmd)
            pnt_pkg::CMD_GRAD: begin
                grad_mem[s.idx][0] = s.gx;
                grad_mem[s.idx][1] = s.gy;
                grad_mem[s.idx][2] = s.gz;
                n_writes++;
            end
            pnt_pkg::CMD_PERM_X: begin perm_mem[0][s.idx] = s.pv; n_writes++; end
            pnt_pkg::CMD_PERM_Y: begin perm_mem[1][s.idx] = s.pv; n_writes++; end
            pnt_pkg::CMD_PERM_Z: begin perm_mem[2][s.idx] = s.pv; n_writes++; end
            pnt_pkg::CMD_EVAL: begin
                noise_expected_q.push_back(s.typed ? s.want : turbulence(s));
                n_evals++;
            end
            default: ;
        endcase
    endtask

    function automatic t_stim rand_item();
        t_stim s;
        int sel;
        s.cmd   = pnt_pkg::CMD_EVAL;
        s.idx   = 8'($urandom);
        s.gx    = 16'($urandom_range(0, 32768) - 16384);
        s.gy    = 16'($urandom_range(0, 32768) - 16384);
        s.gz    = 16'($urandom_range(0, 32768) - 16384);
        s.pv    = 8'($urandom);
        s.px    = $urandom;
        s.py    = $urandom;
        s.pz    = $urandom;
        s.oct   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
        s.typed = 1'b0;
        s.want  = '0;
        sel = $urandom_range(0, 99);
        if (sel < 20)
            s.cmd = pnt_pkg::CMD_GRAD;
        else if (sel < 32)
            s.cmd = 3'($urandom_range(pnt_pkg::CMD_PERM_X, pnt_pkg::CMD_PERM_Z));
        else if (sel < 38)
            s.cmd = 3'($urandom_range(CMD_RSVD_A, CMD_LAST));
        else if (sel < 55) begin
            // Points close to the origin, negative cells included.
            s.px = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            s.py = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            s.pz = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        end
        return s;
    endfunction

    function automatic t_stim row(logic [2:0] cmd, logic [7:0] idx, int gx, int gy,
                                  int gz, logic [7:0] pv, logic [31:0] px,
                                  logic [31:0] py, logic [31:0] pz, logic [3:0] oct,
                                  bit typed, logic [pnt_pkg::OUT_W-1:0] want);
        t_stim s;
        s = '{cmd, idx, 16'(gx), 16'(gy), 16'(gz), pv, px, py, pz, oct, typed, want};
        return s;
    endfunction

    // Result side: check each transfer, drive the stall pattern, run the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                n_results++;
                if (noise_expected_q.size() == 0) begin
                    $error("unexpected result noise_value=%0d", o_noise_value);
                    errors++;
                end else begin
                    if (o_noise_value !== noise_expected_q[0]) begin
                        $error("noise_value expected %0d actual %0d",
                               noise_expected_q[0], o_noise_value);
                        errors++;
                    end
                    void'(noise_expected_q.pop_front());
                end
            end
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
        // Rotate between free-running windows, windows of heavy stalls and windows of light stalls.
        stall_phase <= stall_phase + 1;
        if (((stall_phase / 300) % 3) == 0)
            pop <= 1'b1;
        else if (((stall_phase / 300) % 3) == 1)
            pop <= ($urandom_range(0, 3) == 0);
        else
            pop <= ($urandom_range(0, 9) < 7);
    end

    initial begin
        t_stim dir_rows[$];
        t_stim s;
        int gap;
        int burst;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every entry is written before any evaluate reads it.
        for (int i = 0; i < pnt_pkg::TABLE_SIZE; i++) begin
            s = rand_item();
            s.idx = 8'(i);
            s.cmd = pnt_pkg::CMD_GRAD;
            send(s);
            for (int t = 0; t < 3; t++) begin
                s.cmd = 3'(pnt_pkg::CMD_PERM_X + t);
                s.pv  = 8'($urandom);
                send(s);
            end
        end

        dir_rows = '{
            row(pnt_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 32'h0, 32'h0, 32'h0, 4'd1, 1, 0),
            row(pnt_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 32'h1234_5678, 32'h9abc_def0,
                32'h0f0f_f0f0, 4'd0, 1, 0),
            row(pnt_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 32'h0005_0000, 32'hfffd_0000,
                32'h7fff_0000, 4'd8, 1, 0),
            row(pnt_pkg::CMD_GRAD, 8'd0, -16384, 16384, -16384, 0, 0, 0, 0, 0, 0, 0),
            row(pnt_pkg::CMD_GRAD, 8'd255, 16384, -16384, 16384, 0, 0, 0, 0, 0, 0, 0),
            row(pnt_pkg::CMD_PERM_X, 8'd0, 0, 0, 0, 8'd255, 0, 0, 0, 0, 0, 0),
            row(pnt_pkg::CMD_PERM_Y, 8'd255, 0, 0, 0, 8'd0, 0, 0, 0, 0, 0, 0),
            row(pnt_pkg::CMD_PERM_Z, 8'd128, 0, 0, 0, 8'haa, 0, 0, 0, 0, 0, 0),
            row(CMD_RSVD_A, 8'd1, 1, 1, 1, 8'd1, 32'h1, 32'h1, 32'h1, 4'd1, 0, 0),
            row(CMD_RSVD_B, 8'd2, 2, 2, 2, 8'd2, 32'h2, 32'h2, 32'h2, 4'd2, 0, 0),
            row(CMD_LAST, 8'd3, 3, 3, 3, 8'd3, 32'h3, 32'h3, 32'h3, 4'd3, 0, 0),
            row(pnt_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
                4'd1, 0, 0),
            row(pnt_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, 4'd8, 0, 0),
            row(pnt_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 4'd15, 0, 0),
            row(pnt_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 32'hffff_ffff, 32'hffff_8000,
                32'h0000_8000, 4'd3, 0, 0),
            row(pnt_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 32'h0000_ffff, 32'h00ff_0001,
                32'hff00_7fff, 4'd9, 0, 0),
            row(pnt_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 32'h0001_8000, 32'hfffe_c000,
                32'h0000_4000, 4'd4, 0, 0)
        };
        foreach (dir_rows[i])
            send(dir_rows[i]);

        burst = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            send(rand_item());
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                if (gap > 0) begin
                    push <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end else begin
                burst--;
            end
        end
        push <= 1'b0;

        while (noise_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d evaluate transfers and %0d table writes, %0d results checked.",
                 n_evals, n_writes, n_results);
        $display("Octave counts from zero past the maximum and extreme points included.");
        if (errors == 0 && noise_expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
